// ----- hdl/kfc_pkg.sv -----
// Shared types and constants for the keypad four-function calculator.
// Used by kfc_ctrl, kfc_dp and keypad_four_function_calculator; no dependencies.
package kfc_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned ITER_STEPS = DATA_W;
    localparam int unsigned CNT_W     = $clog2(ITER_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ITER_STEPS - 1);

    localparam logic signed [DATA_W-1:0] ENTRY_LIMIT = 32'sd9999999;

    typedef enum logic [1:0] {
        KIND_DIGIT    = 2'd0,
        KIND_OPERATOR = 2'd1,
        KIND_EQUALS   = 2'd2,
        KIND_CLEAR    = 2'd3
    } kind_t;

    // pending operator codes as held in the latch and shown on the output
    localparam logic [2:0] PEND_NONE = 3'd0;
    localparam logic [2:0] PEND_ADD  = 3'd1;
    localparam logic [2:0] PEND_SUB  = 3'd2;
    localparam logic [2:0] PEND_MUL  = 3'd3;
    localparam logic [2:0] PEND_DIV  = 3'd4;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  digit;
        logic [1:0]  operator_code;
    } key_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] shown_value;
        logic [2:0]               pending_operator;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ITER,
        ST_COMMIT,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic apply_key;
        logic start_iter;
        logic step_iter;
        logic commit_eval;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  iter_needed;
        logic  iter_last;
    } status_t;

endpackage

// ----- hdl/kfc_ctrl.sv -----
// Control state machine for the calculator: sequences key decode, the
// iterative multiply/divide and the output beat. Depends on kfc_pkg.
module kfc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  kfc_pkg::status_t status,
    output kfc_pkg::cmd_t    cmd
);

    kfc_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == kfc_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kfc_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = kfc_pkg::ST_DECODE;
            end
            kfc_pkg::ST_DECODE:
            begin
                if (status.kind inside {kfc_pkg::KIND_DIGIT, kfc_pkg::KIND_CLEAR})
                    state_next = kfc_pkg::ST_OUTPUT;
                else if (status.iter_needed)
                    state_next = kfc_pkg::ST_ITER;
                else
                    state_next = kfc_pkg::ST_OUTPUT;
            end
            kfc_pkg::ST_ITER:
            begin
                if (status.iter_last)
                    state_next = kfc_pkg::ST_COMMIT;
            end
            kfc_pkg::ST_COMMIT:
            begin
                state_next = kfc_pkg::ST_OUTPUT;
            end
            kfc_pkg::ST_OUTPUT:
            begin
                if (out_free)
                    state_next = kfc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = kfc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            kfc_pkg::ST_IDLE:
            begin
                cmd.capture = in_valid;
            end
            kfc_pkg::ST_DECODE:
            begin
                if (status.kind inside {kfc_pkg::KIND_DIGIT, kfc_pkg::KIND_CLEAR})
                    cmd.apply_key = 1'b1;
                else if (status.iter_needed)
                    cmd.start_iter = 1'b1;
                else
                    cmd.commit_eval = 1'b1;
            end
            kfc_pkg::ST_ITER:
            begin
                cmd.step_iter = 1'b1;
            end
            kfc_pkg::ST_COMMIT:
            begin
                cmd.commit_eval = 1'b1;
            end
            kfc_pkg::ST_OUTPUT:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kfc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- hdl/kfc_dp.sv -----
// Datapath for the calculator: accumulator, entry, operator latch, a shared
// one-bit-per-cycle shift-add multiplier / restoring divider and the output
// register. Depends on kfc_pkg.
module kfc_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  kfc_pkg::key_t     in_data,
    input  kfc_pkg::cmd_t     cmd,
    output kfc_pkg::status_t  status,
    output kfc_pkg::result_t  out_data
);

    localparam int unsigned W = kfc_pkg::DATA_W;

    kfc_pkg::key_t    key_reg;
    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     entry_reg, entry_next;
    logic [2:0]       op_reg, op_next;
    logic [W-1:0]     shown_reg, shown_next;
    kfc_pkg::result_t out_reg;

    // shared iterative unit: multiplicand/divisor, multiplier/quotient,
    // product/remainder
    logic [W-1:0]     work_a_reg, work_a_next;
    logic [W-1:0]     work_q_reg, work_q_next;
    logic [W-1:0]     work_r_reg, work_r_next;
    logic [kfc_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    logic             is_div;
    logic             acc_neg, entry_neg;
    logic [W-1:0]     acc_mag, entry_mag;
    logic [W:0]       trial;
    logic [W-1:0]     entry_x10;
    logic [W-1:0]     eval_r;

    assign is_div    = (op_reg == kfc_pkg::PEND_DIV);
    assign acc_neg   = acc_reg[W-1];
    assign entry_neg = entry_reg[W-1];
    assign acc_mag   = acc_neg ? (~acc_reg + 1'b1) : acc_reg;
    assign entry_mag = entry_neg ? (~entry_reg + 1'b1) : entry_reg;
    assign trial     = {work_r_reg, work_q_reg[W-1]} - {1'b0, work_a_reg};
    assign entry_x10 = (entry_reg << 3) + (entry_reg << 1) + W'(key_reg.digit);

    assign status.kind        = key_reg.kind;
    assign status.iter_needed = (op_reg == kfc_pkg::PEND_MUL) || is_div;
    assign status.iter_last   = (cnt_reg == kfc_pkg::CNT_LAST);

    assign out_data = out_reg;

    always_comb
    begin
        case (op_reg)
            kfc_pkg::PEND_ADD: eval_r = acc_reg + entry_reg;
            kfc_pkg::PEND_SUB: eval_r = acc_reg - entry_reg;
            kfc_pkg::PEND_MUL: eval_r = work_r_reg;
            kfc_pkg::PEND_DIV:
            begin
                if (entry_reg == '0)
                    eval_r = '0;
                else if (acc_neg != entry_neg)
                    eval_r = ~work_q_reg + 1'b1;
                else
                    eval_r = work_q_reg;
            end
            default:           eval_r = entry_reg;
        endcase
    end

    always_comb
    begin
        work_a_next = work_a_reg;
        work_q_next = work_q_reg;
        work_r_next = work_r_reg;
        cnt_next    = cnt_reg;
        if (cmd.start_iter)
        begin
            work_a_next = is_div ? entry_mag : acc_reg;
            work_q_next = is_div ? acc_mag : entry_reg;
            work_r_next = '0;
            cnt_next    = '0;
        end
        else if (cmd.step_iter)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (is_div)
            begin
                // keep the trial remainder when it did not go negative
                if (!trial[W])
                begin
                    work_r_next = trial[W-1:0];
                    work_q_next = {work_q_reg[W-2:0], 1'b1};
                end
                else
                begin
                    work_r_next = {work_r_reg[W-2:0], work_q_reg[W-1]};
                    work_q_next = {work_q_reg[W-2:0], 1'b0};
                end
            end
            else
            begin
                if (work_q_reg[0])
                    work_r_next = work_r_reg + work_a_reg;
                work_a_next = work_a_reg << 1;
                work_q_next = work_q_reg >> 1;
            end
        end
    end

    always_comb
    begin
        acc_next   = acc_reg;
        entry_next = entry_reg;
        op_next    = op_reg;
        shown_next = shown_reg;
        if (cmd.apply_key)
        begin
            if (key_reg.kind == kfc_pkg::KIND_CLEAR)
            begin
                acc_next   = '0;
                entry_next = '0;
                op_next    = kfc_pkg::PEND_NONE;
                shown_next = '0;
            end
            else
            begin
                if ($signed(entry_reg) < kfc_pkg::ENTRY_LIMIT)
                    entry_next = entry_x10;
                shown_next = entry_next;
            end
        end
        else if (cmd.commit_eval)
        begin
            acc_next   = eval_r;
            shown_next = eval_r;
            if (key_reg.kind == kfc_pkg::KIND_OPERATOR)
            begin
                entry_next = '0;
                op_next    = 3'(key_reg.operator_code) + 3'd1;
            end
            else
            begin
                entry_next = eval_r;
                op_next    = kfc_pkg::PEND_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            entry_reg <= '0;
            op_reg    <= kfc_pkg::PEND_NONE;
        end
        else
        begin
            acc_reg   <= acc_next;
            entry_reg <= entry_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            key_reg <= in_data;
        shown_reg  <= shown_next;
        work_a_reg <= work_a_next;
        work_q_reg <= work_q_next;
        work_r_reg <= work_r_next;
        cnt_reg    <= cnt_next;
        if (cmd.load_out)
        begin
            out_reg.shown_value      <= $signed(shown_reg);
            out_reg.pending_operator <= op_reg;
        end
    end

endmodule

// ----- hdl/keypad_four_function_calculator.sv -----
// Keypad four-function calculator: one key press per input beat, one result beat per key.
// Digit and clear keys, and operator or equals keys with no pending multiply or divide,
// go IDLE, DECODE, OUTPUT; under a pending multiply or divide a key also runs 32 steps of
// the shared shift-add / restoring unit in ITER, then COMMIT. Keys are accepted in IDLE.
// Reset (rst_n low, asynchronous) zeroes accumulator, entry and pending operator.
// Depends on kfc_pkg, kfc_ctrl and kfc_dp.
module keypad_four_function_calculator (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  kfc_pkg::key_t    in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output kfc_pkg::result_t out_data
);

    kfc_pkg::cmd_t    cmd;
    kfc_pkg::status_t status;

    kfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    kfc_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule
